// ----- rtl/chc_pkg.sv -----
// Shared constants and pipeline sideband types for the crater height carve block.
package chc_pkg;

   // configuration register indexes
   localparam logic CSR_MODE  = 1'b0;
   localparam logic CSR_RATIO = 1'b1;

   localparam logic [1:0]  MODE_PARABOLIC = 2'd0;
   localparam logic [15:0] RATIO_RESET    = 16'd13107;

   // divider: 63-bit dividend, 34-bit divisor, one quotient bit per stage
   localparam int DIV_BITS = 63;
   localparam int DVS_W    = 34;

   // square root: 120-bit radicand, 60-bit root, one root bit per stage
   localparam int RAD_W    = 120;
   localparam int ROOT_W   = 60;
   localparam int SQREM_W  = 62;

   typedef struct packed {
      logic signed [31:0] h;
      logic               hit;
      logic               act;
      logic               bowl;
      logic               czero;
      logic [30:0]        c;
      logic [59:0]        s;
   } div_side_type;

   typedef struct packed {
      logic signed [31:0] h;
      logic               hit;
      logic               act;
      logic               bowl;
      logic               czero;
      logic [30:0]        c;
      logic signed [31:0] zp;
      logic [59:0]        sph;
   } sqrt_side_type;

endpackage

// ----- rtl/chc_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, with sideband.
module chc_div import chc_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                adv,
   input  logic                in_vld,
   input  logic [DIV_BITS-1:0] in_num,
   input  logic [DVS_W-1:0]    in_dvs,
   input  div_side_type        in_side,
   output logic                out_vld,
   output logic [DIV_BITS-1:0] out_quo,
   output div_side_type        out_side
);

   logic                vld_ff  [DIV_BITS];
   logic [DIV_BITS-1:0] nq_ff   [DIV_BITS];   // dividend bits shift out, quotient bits in
   logic [DVS_W-1:0]    rem_ff  [DIV_BITS];
   logic [DVS_W-1:0]    dvs_ff  [DIV_BITS];
   div_side_type        side_ff [DIV_BITS];

   for (genvar i = 0; i < DIV_BITS; i++) begin : g_stage
      logic                vld_pre;
      logic [DIV_BITS-1:0] nq_pre;
      logic [DVS_W-1:0]    rem_pre;
      logic [DVS_W-1:0]    dvs_pre;
      div_side_type        side_pre;
      logic [DVS_W:0]      trial;
      logic [DVS_W:0]      diff;
      logic                take;
      logic [DIV_BITS-1:0] nq_in;
      logic [DVS_W-1:0]    rem_in;

      if (i == 0) begin : g_first
         assign vld_pre  = in_vld;
         assign nq_pre   = in_num;
         assign rem_pre  = '0;
         assign dvs_pre  = in_dvs;
         assign side_pre = in_side;
      end else begin : g_next
         assign vld_pre  = vld_ff[i-1];
         assign nq_pre   = nq_ff[i-1];
         assign rem_pre  = rem_ff[i-1];
         assign dvs_pre  = dvs_ff[i-1];
         assign side_pre = side_ff[i-1];
      end

      assign trial  = {rem_pre, nq_pre[DIV_BITS-1]};
      assign take   = trial >= {1'b0, dvs_pre};
      assign diff   = trial - {1'b0, dvs_pre};
      assign nq_in  = {nq_pre[DIV_BITS-2:0], take};
      assign rem_in = take ? diff[DVS_W-1:0] : trial[DVS_W-1:0];

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i] <= 1'b0;
         end else if (adv) begin
            vld_ff[i] <= vld_pre;
         end
         if (adv) begin
            nq_ff[i]   <= nq_in;
            rem_ff[i]  <= rem_in;
            dvs_ff[i]  <= dvs_pre;
            side_ff[i] <= side_pre;
         end
      end
   end

   assign out_vld  = vld_ff[DIV_BITS-1];
   assign out_quo  = nq_ff[DIV_BITS-1];
   assign out_side = side_ff[DIV_BITS-1];

endmodule

// ----- rtl/chc_sqrt.sv -----
// Pipelined digit-by-digit integer square root, one root bit per stage, with sideband.
module chc_sqrt import chc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  logic              in_vld,
   input  logic [RAD_W-1:0]  in_rad,
   input  sqrt_side_type     in_side,
   output logic              out_vld,
   output logic [ROOT_W-1:0] out_root,
   output sqrt_side_type     out_side
);

   logic               vld_ff  [ROOT_W];
   logic [RAD_W-1:0]   x_ff    [ROOT_W];
   logic [SQREM_W-1:0] rem_ff  [ROOT_W];
   logic [ROOT_W-1:0]  root_ff [ROOT_W];
   sqrt_side_type      side_ff [ROOT_W];

   for (genvar i = 0; i < ROOT_W; i++) begin : g_stage
      logic               vld_pre;
      logic [RAD_W-1:0]   x_pre;
      logic [SQREM_W-1:0] rem_pre;
      logic [ROOT_W-1:0]  root_pre;
      sqrt_side_type      side_pre;
      logic [SQREM_W+1:0] cur;
      logic [SQREM_W+1:0] trial;
      logic [SQREM_W+1:0] diff;
      logic               take;
      logic [RAD_W-1:0]   x_in;
      logic [SQREM_W-1:0] rem_in;
      logic [ROOT_W-1:0]  root_in;

      if (i == 0) begin : g_first
         assign vld_pre  = in_vld;
         assign x_pre    = in_rad;
         assign rem_pre  = '0;
         assign root_pre = '0;
         assign side_pre = in_side;
      end else begin : g_next
         assign vld_pre  = vld_ff[i-1];
         assign x_pre    = x_ff[i-1];
         assign rem_pre  = rem_ff[i-1];
         assign root_pre = root_ff[i-1];
         assign side_pre = side_ff[i-1];
      end

      assign cur     = {rem_pre, x_pre[RAD_W-1 -: 2]};
      assign trial   = {2'b00, root_pre, 2'b01};
      assign take    = cur >= trial;
      assign diff    = cur - trial;
      assign rem_in  = take ? diff[SQREM_W-1:0] : cur[SQREM_W-1:0];
      assign root_in = {root_pre[ROOT_W-2:0], take};
      assign x_in    = {x_pre[RAD_W-3:0], 2'b00};

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i] <= 1'b0;
         end else if (adv) begin
            vld_ff[i] <= vld_pre;
         end
         if (adv) begin
            x_ff[i]    <= x_in;
            rem_ff[i]  <= rem_in;
            root_ff[i] <= root_in;
            side_ff[i] <= side_pre;
         end
      end
   end

   assign out_vld  = vld_ff[ROOT_W-1];
   assign out_root = root_ff[ROOT_W-1];
   assign out_side = side_ff[ROOT_W-1];

endmodule

// ----- rtl/crater_height_carve_top.sv -----
// Crater height carve: new height of one grid point under one crater profile.
// Pipeline: 133 register stages.
// Throughput: one request per cycle; the 63-stage divider and 60-stage square
// root are fully pipelined and the whole pipe advances unless the result is stalled.
// Reset clears all stage valid bits and sets profile_mode 0, depth_ratio 13107.
module crater_height_carve_top import chc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_point_x,
   input  logic signed [31:0] req_point_y,
   input  logic signed [31:0] req_height_now,
   input  logic signed [31:0] req_centre_x,
   input  logic signed [31:0] req_centre_y,
   input  logic [30:0]        req_diameter,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_height_new,
   output logic               rsp_inside_res,
   input  logic               csr_write_en,
   input  logic               csr_index,
   input  logic [15:0]        csr_wdata
);

   localparam logic signed [61:0] Z_MAX = 62'sd2147483647;
   localparam logic signed [61:0] Z_MIN = -62'sd2147483648;

   logic        adv;
   logic [1:0]  mode_ff;
   logic [15:0] ratio_ff;

   assign adv       = !rsp_valid || !rsp_stall;
   assign req_stall = !adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_PARABOLIC;
         ratio_ff <= RATIO_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_MODE:  mode_ff  <= csr_wdata[1:0];
            CSR_RATIO: ratio_ff <= csr_wdata;
            default:   mode_ff  <= mode_ff;
         endcase
      end
   end

   // stage a: offsets, magnitudes, bounding box
   logic signed [32:0] dx, dy;
   logic [32:0]        ax, ay;
   logic               box;
   logic               a_vld_ff, a_box_ff;
   logic [29:0]        a_ax_ff, a_ay_ff;
   logic signed [31:0] a_h_ff;
   logic [30:0]        a_d_ff;

   assign dx  = 33'(req_point_x) - 33'(req_centre_x);
   assign dy  = 33'(req_point_y) - 33'(req_centre_y);
   assign ax  = dx[32] ? 33'(-dx) : 33'(dx);
   assign ay  = dy[32] ? 33'(-dy) : 33'(dy);
   assign box = ({ax, 1'b0} <= {3'b000, req_diameter}) &&
                ({ay, 1'b0} <= {3'b000, req_diameter});

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
      end else if (adv) begin
         a_vld_ff <= req_valid;
      end
      if (adv) begin
         a_box_ff <= box;
         a_ax_ff  <= box ? ax[29:0] : '0;
         a_ay_ff  <= box ? ay[29:0] : '0;
         a_h_ff   <= req_height_now;
         a_d_ff   <= req_diameter;
      end
   end

   // stage b: squares and k*D
   logic               b_vld_ff, b_box_ff;
   logic [59:0]        b_sqx_ff, b_sqy_ff;
   logic [61:0]        b_dd_ff;
   logic [46:0]        b_kd_ff;
   logic signed [31:0] b_h_ff;
   logic [30:0]        b_d_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_vld_ff <= 1'b0;
      end else if (adv) begin
         b_vld_ff <= a_vld_ff;
      end
      if (adv) begin
         b_box_ff <= a_box_ff;
         b_sqx_ff <= a_ax_ff * a_ax_ff;
         b_sqy_ff <= a_ay_ff * a_ay_ff;
         b_dd_ff  <= a_d_ff * a_d_ff;
         b_kd_ff  <= ratio_ff * a_d_ff;
         b_h_ff   <= a_h_ff;
         b_d_ff   <= a_d_ff;
      end
   end

   // stage c: squared distance and radius test
   logic [60:0]        s_sum;
   logic               hit;
   logic               c_vld_ff, c_inside_ff;
   logic [59:0]        c_s_ff;
   logic [30:0]        c_c_ff;
   logic [61:0]        c_dd_ff;
   logic signed [31:0] c_h_ff;
   logic [30:0]        c_d_ff;

   assign s_sum = {1'b0, b_sqx_ff} + {1'b0, b_sqy_ff};
   assign hit   = b_box_ff && ({s_sum, 2'b00} <= {1'b0, b_dd_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         c_vld_ff <= 1'b0;
      end else if (adv) begin
         c_vld_ff <= b_vld_ff;
      end
      if (adv) begin
         c_inside_ff <= hit;
         c_s_ff      <= hit ? s_sum[59:0] : '0;
         c_c_ff      <= b_kd_ff[46:16];
         c_dd_ff     <= b_dd_ff;
         c_h_ff      <= b_h_ff;
         c_d_ff      <= b_d_ff;
      end
   end

   // stage p: divider operands; parabolic (D^2-4s)/D, bowl (D^2+4c*odd)/(8c)
   logic                bowl;
   logic [DIV_BITS-1:0] num_in;
   logic [DVS_W-1:0]    dvs_raw, dvs_in;
   div_side_type        dside_in;
   logic                p_vld_ff;
   logic [DIV_BITS-1:0] p_num_ff;
   logic [DVS_W-1:0]    p_dvs_ff;
   div_side_type        p_side_ff;

   assign bowl    = mode_ff != MODE_PARABOLIC;
   assign num_in  = bowl ? ({1'b0, c_dd_ff} + (c_c_ff[0] ? {30'b0, c_c_ff, 2'b00} : '0))
                         : ({1'b0, c_dd_ff} - {1'b0, c_s_ff, 2'b00});
   assign dvs_raw = bowl ? {c_c_ff, 3'b000} : {3'b000, c_d_ff};
   assign dvs_in  = (dvs_raw == '0) ? DVS_W'(1) : dvs_raw;

   always_comb begin
      dside_in.h     = c_h_ff;
      dside_in.hit   = c_inside_ff;
      dside_in.act   = c_inside_ff && (c_d_ff != '0) && (ratio_ff != '0);
      dside_in.bowl  = bowl;
      dside_in.czero = c_c_ff == '0;
      dside_in.c     = c_c_ff;
      dside_in.s     = c_s_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_vld_ff <= 1'b0;
      end else if (adv) begin
         p_vld_ff <= c_vld_ff;
      end
      if (adv) begin
         p_num_ff  <= num_in;
         p_dvs_ff  <= dvs_in;
         p_side_ff <= dside_in;
      end
   end

   logic                dv_vld;
   logic [DIV_BITS-1:0] dv_quo;
   div_side_type        dv_side;

   chc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_vld   (p_vld_ff),
      .in_num   (p_num_ff),
      .in_dvs   (p_dvs_ff),
      .in_side  (p_side_ff),
      .out_vld  (dv_vld),
      .out_quo  (dv_quo),
      .out_side (dv_side)
   );

   // stage f: parabolic k*t, bowl sphere radius
   logic         f_vld_ff;
   logic [46:0]  f_prod_ff;
   logic [59:0]  f_sph_ff;
   div_side_type f_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         f_vld_ff <= 1'b0;
      end else if (adv) begin
         f_vld_ff <= dv_vld;
      end
      if (adv) begin
         f_prod_ff <= ratio_ff * dv_quo[30:0];
         f_sph_ff  <= {30'b0, dv_side.c[30:1]} + dv_quo[59:0];
         f_side_ff <= dv_side;
      end
   end

   // stage g: parabolic depth, partial products of sph^2
   logic               g_vld_ff;
   logic signed [31:0] g_zp_ff;
   logic [59:0]        g_hh_ff, g_hl_ff, g_ll_ff;
   logic [59:0]        g_sph_ff;
   div_side_type       g_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         g_vld_ff <= 1'b0;
      end else if (adv) begin
         g_vld_ff <= f_vld_ff;
      end
      if (adv) begin
         g_zp_ff   <= -$signed({1'b0, f_prod_ff[46:16]});
         g_hh_ff   <= f_sph_ff[59:30] * f_sph_ff[59:30];
         g_hl_ff   <= f_sph_ff[59:30] * f_sph_ff[29:0];
         g_ll_ff   <= f_sph_ff[29:0] * f_sph_ff[29:0];
         g_sph_ff  <= f_sph_ff;
         g_side_ff <= f_side_ff;
      end
   end

   // stage h: sph^2
   logic               h_vld_ff;
   logic [RAD_W-1:0]   h_sq_ff;
   logic signed [31:0] h_zp_ff;
   logic [59:0]        h_sph_ff;
   div_side_type       h_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         h_vld_ff <= 1'b0;
      end else if (adv) begin
         h_vld_ff <= g_vld_ff;
      end
      if (adv) begin
         h_sq_ff   <= {g_hh_ff, 60'b0} + {29'b0, g_hl_ff, 31'b0} + {60'b0, g_ll_ff};
         h_zp_ff   <= g_zp_ff;
         h_sph_ff  <= g_sph_ff;
         h_side_ff <= g_side_ff;
      end
   end

   // stage r: radicand sph^2 - s, floored at zero
   logic [RAD_W-1:0] rad_in;
   sqrt_side_type    qside_in;
   logic             r_vld_ff;
   logic [RAD_W-1:0] r_rad_ff;
   sqrt_side_type    r_side_ff;

   assign rad_in = (h_sq_ff >= {60'b0, h_side_ff.s}) ? h_sq_ff - {60'b0, h_side_ff.s} : '0;

   always_comb begin
      qside_in.h     = h_side_ff.h;
      qside_in.hit   = h_side_ff.hit;
      qside_in.act   = h_side_ff.act;
      qside_in.bowl  = h_side_ff.bowl;
      qside_in.czero = h_side_ff.czero;
      qside_in.c     = h_side_ff.c;
      qside_in.zp    = h_zp_ff;
      qside_in.sph   = h_sph_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         r_vld_ff <= 1'b0;
      end else if (adv) begin
         r_vld_ff <= h_vld_ff;
      end
      if (adv) begin
         r_rad_ff  <= rad_in;
         r_side_ff <= qside_in;
      end
   end

   logic              sq_vld;
   logic [ROOT_W-1:0] sq_root;
   sqrt_side_type     sq_side;

   chc_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_vld   (r_vld_ff),
      .in_rad   (r_rad_ff),
      .in_side  (r_side_ff),
      .out_vld  (sq_vld),
      .out_root (sq_root),
      .out_side (sq_side)
   );

   // stage j: profile depth
   logic signed [61:0] zb;
   logic               j_vld_ff, j_act_ff, j_inside_ff;
   logic signed [61:0] j_z_ff;
   logic signed [31:0] j_h_ff;

   assign zb = sq_side.czero ? '0
             : $signed({2'b00, sq_side.sph} - {31'b0, sq_side.c} - {2'b00, sq_root});

   always_ff @(posedge clock) begin
      if (reset) begin
         j_vld_ff <= 1'b0;
      end else if (adv) begin
         j_vld_ff <= sq_vld;
      end
      if (adv) begin
         j_z_ff      <= sq_side.bowl ? zb : 62'(sq_side.zp);
         j_act_ff    <= sq_side.act;
         j_inside_ff <= sq_side.hit;
         j_h_ff      <= sq_side.h;
      end
   end

   // output stage: saturate and take the lower surface
   logic signed [31:0] zsat, res;
   logic               rsp_valid_ff, rsp_inside_ff;
   logic signed [31:0] rsp_height_ff;

   always_comb begin
      priority if (j_z_ff > Z_MAX) begin
         zsat = 32'sh7fffffff;
      end else if (j_z_ff < Z_MIN) begin
         zsat = 32'sh80000000;
      end else begin
         zsat = j_z_ff[31:0];
      end
      res = (j_act_ff && (zsat < j_h_ff)) ? zsat : j_h_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= j_vld_ff;
      end
      if (adv) begin
         rsp_height_ff <= res;
         rsp_inside_ff <= j_inside_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_height_new = rsp_height_ff;
   assign rsp_inside_res = rsp_inside_ff;

endmodule

// ----- rtl/chc_check.sv -----
// Port-level checks for the crater height carve top level, bound to it.
module chc_check (
   input logic               clock,
   input logic               reset,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic signed [31:0] rsp_height_new,
   input logic               rsp_inside_res
);

   // pipe only holds requests off while a result is waiting
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("request stalled without a stalled result");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |-> req_stall)
      else $error("request taken while pipe is frozen");

   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
         (rsp_valid && $stable(rsp_height_new) && $stable(rsp_inside_res)))
      else $error("stalled result changed");

endmodule

bind crater_height_carve_top chc_check u_chc_check (
   .clock          (clock),
   .reset          (reset),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_height_new (rsp_height_new),
   .rsp_inside_res (rsp_inside_res)
);

// ----- bench/tb_top.sv -----
// Self-checking testbench for crater_height_carve_top: directed and random streams checked against a predictor.
module tb_top import chc_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] MODE_BOWL     = 2'd1;
   localparam logic [1:0] MODE_BOWL_ALT = 2'd2;
   localparam logic [1:0] MODE_BOWL_OLD = 2'd3;
   localparam int         DRAIN_CYCLES  = 150;
   localparam int         WATCHDOG_MAX  = 20000;

   typedef struct {
      logic signed [31:0] px, py, h, cx, cy;
      logic [30:0]        d;
   } crater_req_type;

   typedef struct {
      logic signed [31:0] height;
      logic               hit;
   } carve_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [31:0] rsp_height_new;
   logic rsp_inside_res;
   logic csr_write_en = 1'b0;
   logic csr_index = CSR_MODE;
   logic [15:0] csr_wdata = '0;
   crater_req_type cur_req = '{default: '0};

   crater_req_type pending[$];
   carve_type      carve_expect[$];
   logic [1:0]  cfg_mode  = MODE_PARABOLIC;
   logic [15:0] cfg_ratio = RATIO_RESET;
   bit          req_fire = 0;
   int          mismatches = 0;
   int          accepted_reqs = 0;
   int          idle_cycles = 0;

   crater_height_carve_top u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_point_x(cur_req.px), .req_point_y(cur_req.py),
      .req_height_now(cur_req.h), .req_centre_x(cur_req.cx),
      .req_centre_y(cur_req.cy), .req_diameter(cur_req.d),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_height_new(rsp_height_new), .rsp_inside_res(rsp_inside_res),
      .csr_write_en(csr_write_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic logic [127:0] isqrt(logic [127:0] rad);
      logic [127:0] root, cand;
      root = '0;
      for (int i = 60; i >= 0; i--) begin
         cand = root | (128'd1 << i);
         if (cand * cand <= rad) root = cand;
      end
      return root;
   endfunction

   function automatic carve_type carve(crater_req_type r);
      logic signed [63:0]  dx, dy;
      logic [127:0]        ax, ay, s, dd, k, t, c, sph, rad;
      logic signed [127:0] z;
      carve_type o;
      dx = 64'(r.px) - 64'(r.cx);
      dy = 64'(r.py) - 64'(r.cy);
      ax = 128'(dx < 0 ? -dx : dx);
      ay = 128'(dy < 0 ? -dy : dy);
      dd = 128'(r.d);
      k = 128'(cfg_ratio);
      s = '0;
      o.height = r.h;
      o.hit = 1'b0;
      if (2 * ax <= dd && 2 * ay <= dd) begin
         s = ax * ax + ay * ay;
         o.hit = (4 * s <= dd * dd);
      end
      if (o.hit && dd != 0 && k != 0) begin
         if (cfg_mode == MODE_PARABOLIC) begin
            t = (dd * dd - 4 * s) / dd;
            z = -$signed((k * t) >> 16);
         end else begin
            c = (k * dd) >> 16;
            if (c == 0) begin
               z = '0;
            end else begin
               sph = (c >> 1) + (dd * dd + 4 * (c & 1) * c) / (8 * c);
               rad = (sph * sph < s) ? 128'd0 : sph * sph - s;
               z = $signed(sph) - $signed(c) - $signed(isqrt(rad));
            end
         end
         if (z > 128'sd2147483647) z = 128'sd2147483647;
         if (z < -128'sd2147483648) z = -128'sd2147483648;
         if (z < 128'(r.h)) o.height = z[31:0];
      end
      return o;
   endfunction

   // request side: bursts with random gaps
   int burst_left = 0, gap_left = 0;
   always @(negedge clock) begin
      crater_req_type nxt;
      if (!reset && (!req_valid || req_fire)) begin
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pending.size() > 0) begin
            nxt = pending.pop_front();
            cur_req <= nxt;
            req_valid <= 1'b1;
            if (burst_left == 0) burst_left = $urandom_range(1, 40);
            burst_left--;
            if (burst_left == 0)
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result side: random stall patterns that change over time, one long hold-off to back up the pipe
   int hold_cnt = 0, pattern_cnt = 0, stall_pct = 0;
   bit hold_done = 0;
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_cnt > 0) begin
         hold_cnt--;
         rsp_stall <= 1'b1;
      end else if (!hold_done && accepted_reqs >= 150) begin
         hold_done = 1;
         hold_cnt = 400;
         rsp_stall <= 1'b1;
      end else begin
         if (pattern_cnt == 0) begin
            pattern_cnt = 50;
            case ($urandom_range(0, 2))
               0: stall_pct = 0;
               1: stall_pct = 25;
               default: stall_pct = 70;
            endcase
         end
         pattern_cnt--;
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      carve_type want;
      req_fire = req_valid && !req_stall && !reset;
      if (req_fire) begin
         carve_expect.push_back(carve(cur_req));
         accepted_reqs++;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         if (carve_expect.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result height=%0d", rsp_height_new);
         end else begin
            want = carve_expect.pop_front();
            if (want.height !== rsp_height_new || want.hit !== rsp_inside_res) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected height=%0d inside=%0b, got height=%0d inside=%0b",
                           want.height, want.hit, rsp_height_new, rsp_inside_res);
            end
         end
      end
      if (req_fire || (rsp_valid && !rsp_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_MAX) begin
         $display("[crater_height_carve_top] ERROR");
         $finish;
      end
   end

   task automatic write_reg(logic idx, logic [15:0] value);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      if (idx == CSR_MODE) cfg_mode = value[1:0];
      else cfg_ratio = value;
      @(negedge clock);
      csr_write_en <= 1'b0;
   endtask

   task automatic wait_drained();
      do begin
         @(posedge clock);
         #1;
      end while (pending.size() != 0 || req_valid || carve_expect.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic crater_req_type mk(int px, int py, int h, int cx, int cy, int d);
      crater_req_type r;
      r.px = px; r.py = py; r.h = h; r.cx = cx; r.cy = cy; r.d = d[30:0];
      return r;
   endfunction

   task automatic add_directed();
      pending.push_back(mk(0, 0, 0, 0, 0, 32'h0000_2000));                // dead center
      pending.push_back(mk(0, 0, 32'h7fff_ffff, 0, 0, 32'h7fff_ffff));    // widest crater
      pending.push_back(mk(0, 0, 32'h8000_0000, 0, 0, 32'h7fff_ffff));
      pending.push_back(mk(5, 5, 1000, 5, 5, 0));                         // zero diameter
      pending.push_back(mk(32'h1000, 0, 0, 0, 0, 32'h2000));              // on the rim
      pending.push_back(mk(32'h1001, 0, 0, 0, 0, 32'h2000));              // just outside
      pending.push_back(mk(32'h7fff_ffff, 32'h7fff_ffff, 5, 32'h8000_0000,
                           32'h8000_0000, 32'h7fff_ffff));                // far corners
      pending.push_back(mk(32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 32'h7fff_ffff,
                           32'h8000_0000, 32'h7fff_ffff));
      pending.push_back(mk(32'h0c00, 32'h0c00, 32'h7fff_ffff, 0, 0, 32'h2000));
      pending.push_back(mk(3, 4, 100, 0, 0, 10));                         // tiny crater
      pending.push_back(mk(0, 0, 32'h7fff_ffff, 0, 0, 1));
      pending.push_back(mk(0, 0, 32'h7fff_ffff, 0, 0, 32'h4000_0000));
      pending.push_back(mk(32'h2000_0000, 0, 32'h7fff_ffff, 0, 0, 32'h4000_0000));
      pending.push_back(mk(-100, 200, 32'h7fff_ffff, 0, 0, 32'h0100_0000));
   endtask

   task automatic add_random(int count);
      crater_req_type r;
      int unsigned half;
      for (int i = 0; i < count; i++) begin
         case ($urandom_range(0, 3))
            0: r.d = 31'($urandom_range(0, 32'h1_0000));
            1: r.d = 31'($urandom);
            2: r.d = 31'($urandom_range(0, 32'h0100_0000));
            default: r.d = ($urandom_range(0, 9) == 0) ? 31'd0 : 31'($urandom_range(1, 64));
         endcase
         r.cx = $urandom;
         r.cy = $urandom;
         r.h = ($urandom_range(0, 2) == 0) ? 32'($urandom) : $signed($urandom_range(0, 32'h0010_0000));
         half = {1'b0, r.d} >> 1;
         if ($urandom_range(0, 9) < 7) begin
            r.px = r.cx + ($urandom_range(0, 1) ? $urandom_range(0, half) : -$urandom_range(0, half));
            r.py = r.cy + ($urandom_range(0, 1) ? $urandom_range(0, half) : -$urandom_range(0, half));
         end else begin
            r.px = $urandom;
            r.py = $urandom;
         end
         pending.push_back(r);
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      write_reg(CSR_MODE, MODE_PARABOLIC);
      write_reg(CSR_RATIO, RATIO_RESET);
      add_directed();
      add_random(70);
      wait_drained();
      write_reg(CSR_MODE, MODE_BOWL);
      write_reg(CSR_RATIO, 16'hffff);
      add_directed();
      add_random(70);
      wait_drained();
      write_reg(CSR_MODE, MODE_BOWL_ALT);
      write_reg(CSR_RATIO, 16'd1);
      add_random(60);
      wait_drained();
      write_reg(CSR_MODE, MODE_BOWL_OLD);
      write_reg(CSR_RATIO, 16'($urandom));
      add_random(80);
      wait_drained();
      write_reg(CSR_MODE, MODE_PARABOLIC);
      write_reg(CSR_RATIO, 16'd0);                 // zero ratio: height passes through
      add_random(40);
      wait_drained();
      write_reg(CSR_MODE, MODE_BOWL);
      write_reg(CSR_RATIO, 16'd0);
      add_random(30);
      wait_drained();
      write_reg(CSR_MODE, MODE_BOWL);
      write_reg(CSR_RATIO, 16'($urandom));
      add_random(80);
      wait_drained();
      write_reg(CSR_MODE, MODE_PARABOLIC);
      write_reg(CSR_RATIO, 16'hffff);
      add_random(80);
      wait_drained();
      if (mismatches == 0 && carve_expect.size() == 0) begin
         $display("[crater_height_carve_top] OK");
      end else begin
         $display("[crater_height_carve_top] ERROR");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/chc_pkg.sv
rtl/chc_div.sv
rtl/chc_sqrt.sv
rtl/crater_height_carve_top.sv
rtl/chc_check.sv
bench/tb_top.sv
